>>> rtl/core/rwp_pkg.sv
package rwp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int WORD_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_UNIFORM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LR          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS        = 3'd5;

  typedef enum logic [2:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV,
    FOP_CVT
  } fop_t;

  typedef enum logic [3:0] {
    SRC_W,
    SRC_T,
    SRC_S,
    SRC_N,
    SRC_R,
    SRC_EPS,
    SRC_LR,
    SRC_LOSS,
    SRC_GEN,
    SRC_HALF,
    SRC_TWO,
    SRC_SQ3,
    SRC_SQ3X2
  } src_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_T,
    DST_S,
    DST_N
  } dst_t;

  typedef struct packed {
    logic load_item;
    logic seed;
    logic draw;
    logic fpu_start;
    fop_t fpu_op;
    src_t sel_a;
    src_t sel_b;
    dst_t dst;
    logic safe_load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic fpu_done;
    logic first;
    logic use_uniform;
    logic update_mode;
    logic den_zero;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/random_weight_perturbation_top.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    weight_in, first_of_pass
// output    out_valid / out_ready  weight_out
// config    cfg_write              cfg_index, cfg_data
// One weight at a time; every fp operation runs in turn on the single shared fp unit.
// Triangular noise draws two generator values per weight, uniform noise one.
// In update mode a zero divisor skips the divider and loads a NaN or signed infinity instead.
// Reset restores register defaults and the seed-zero generator state.
// A finished result waits in the output register; the next weight is taken meanwhile.
module random_weight_perturbation_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rwp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwp_pkg::WORD_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    weight_in,
  input  logic                           first_of_pass,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    weight_out
);

  rwp_pkg::cmd_t  cmd;
  rwp_pkg::stat_t stat;

  rwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rwp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .weight_in     (weight_in),
    .first_of_pass (first_of_pass),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .weight_out    (weight_out),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

>>> rtl/core/rwp_fpu.sv
module rwp_fpu (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rwp_pkg::fop_t       op,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output logic                done,
  output logic [31:0]         res
);

  localparam logic [31:0] DNAN      = 32'hffc0_0000;
  localparam logic [31:0] QBIT      = 32'h0040_0000;
  localparam int          DIV_STEPS = 48;

  typedef enum logic [2:0] {F_IDLE, F_PREP, F_DIV, F_NORM, F_RND} fstate_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  fstate_t            state;
  rwp_pkg::fop_t      op_r;
  logic [31:0]        a_r, b_r;
  logic               spec;
  logic [31:0]        spec_val;
  logic               sgn;
  logic signed [10:0] e;
  logic [47:0]        m;
  logic               stk;
  logic [25:0]        r;
  logic [23:0]        d;
  logic [5:0]         cnt;
  logic [47:0]        mn;
  logic signed [10:0] en;
  logic               mz;

  // operand preparation
  logic               p_spec;
  logic [31:0]        p_val;
  logic               p_sgn;
  logic signed [10:0] p_e;
  logic [47:0]        p_m;
  logic [25:0]        p_r;
  logic [23:0]        p_d;

  always_comb begin
    logic [7:0]  ea, eb, eax, ebx, big_e, small_e, dsh;
    logic [23:0] ma, mb, big_m, small_m;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sb, sx, a_big, eff_sub;
    logic        big_s, st;
    logic [47:0] big_f, sm_f, al;
    logic [4:0]  lza, lzb;
    ea = a_r[30:23];
    eb = b_r[30:23];
    eax = (ea == 8'd0) ? 8'd1 : ea;
    ebx = (eb == 8'd0) ? 8'd1 : eb;
    ma = {ea != 8'd0, a_r[22:0]};
    mb = {eb != 8'd0, b_r[22:0]};
    a_nan = (ea == 8'hff) && (a_r[22:0] != 23'd0);
    b_nan = (eb == 8'hff) && (b_r[22:0] != 23'd0);
    a_inf = (ea == 8'hff) && (a_r[22:0] == 23'd0);
    b_inf = (eb == 8'hff) && (b_r[22:0] == 23'd0);
    a_zero = a_r[30:0] == 31'd0;
    b_zero = b_r[30:0] == 31'd0;
    sb = b_r[31] ^ (op_r == rwp_pkg::FOP_SUB);
    sx = a_r[31] ^ b_r[31];
    a_big = {eax, ma} >= {ebx, mb};
    big_e = a_big ? eax : ebx;
    small_e = a_big ? ebx : eax;
    big_m = a_big ? ma : mb;
    small_m = a_big ? mb : ma;
    big_s = a_big ? a_r[31] : sb;
    eff_sub = a_r[31] != sb;
    dsh = big_e - small_e;
    big_f = {1'b0, big_m, 23'd0};
    sm_f = {1'b0, small_m, 23'd0};
    if (dsh >= 8'd48) begin
      al = '0;
      st = small_m != 24'd0;
    end else begin
      al = sm_f >> dsh;
      st = |(sm_f & ~({48{1'b1}} << dsh));
    end
    al[0] = al[0] | st;
    lza = lzc24(ma);
    lzb = lzc24(mb);
    p_spec = 1'b0;
    p_val = DNAN;
    p_sgn = 1'b0;
    p_e = 11'sd127;
    p_m = '0;
    p_r = {2'b00, ma << lza};
    p_d = mb << lzb;
    case (op_r)
      rwp_pkg::FOP_ADD, rwp_pkg::FOP_SUB: begin
        p_m = eff_sub ? (big_f - al) : (big_f + al);
        p_sgn = (eff_sub && (p_m == 48'd0)) ? 1'b0 : big_s;
        p_e = 11'(big_e);
        if (a_nan) begin
          p_spec = 1'b1; p_val = a_r | QBIT;
        end else if (b_nan) begin
          p_spec = 1'b1; p_val = b_r | QBIT;
        end else if (a_inf && b_inf && eff_sub) begin
          p_spec = 1'b1; p_val = DNAN;
        end else if (a_inf) begin
          p_spec = 1'b1; p_val = a_r;
        end else if (b_inf) begin
          p_spec = 1'b1; p_val = {sb, b_r[30:0]};
        end
      end
      rwp_pkg::FOP_MUL: begin
        p_sgn = sx;
        p_m = ma * mb;
        p_e = 11'(eax) + 11'(ebx) - 11'sd127;
        if (a_nan) begin
          p_spec = 1'b1; p_val = a_r | QBIT;
        end else if (b_nan) begin
          p_spec = 1'b1; p_val = b_r | QBIT;
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
          p_spec = 1'b1; p_val = DNAN;
        end else if (a_inf || b_inf) begin
          p_spec = 1'b1; p_val = {sx, 8'hff, 23'd0};
        end
      end
      rwp_pkg::FOP_DIV: begin
        p_sgn = sx;
        p_e = (11'(eax) - 11'(lza)) - (11'(ebx) - 11'(lzb)) + 11'sd126;
        if (a_nan) begin
          p_spec = 1'b1; p_val = a_r | QBIT;
        end else if (b_nan) begin
          p_spec = 1'b1; p_val = b_r | QBIT;
        end else if ((a_inf && b_inf) || (a_zero && b_zero)) begin
          p_spec = 1'b1; p_val = DNAN;
        end else if (a_inf || b_zero) begin
          p_spec = 1'b1; p_val = {sx, 8'hff, 23'd0};
        end else if (b_inf || a_zero) begin
          p_spec = 1'b1; p_val = {sx, 31'd0};
        end
      end
      rwp_pkg::FOP_CVT: begin
        p_m = {2'b00, a_r, 14'd0};
      end
      default: begin
        p_spec = 1'b1;
        p_val = DNAN;
      end
    endcase
  end

  // divider step
  logic        div_ge;
  logic [25:0] div_rn;
  assign div_ge = r >= {2'b00, d};
  assign div_rn = div_ge ? (r - {2'b00, d}) : r;

  // rounding
  logic [31:0] rnd_val;
  always_comb begin
    logic signed [10:0] sh;
    logic [47:0] mt;
    logic        st2, inc;
    logic [24:0] r25;
    sh = 11'sd1 - en;
    mt = mn;
    st2 = stk;
    if (en <= 11'sd0) begin
      if (sh >= 11'sd49) begin
        mt = '0;
        st2 = stk | (mn != 48'd0);
      end else begin
        mt = mn >> sh[5:0];
        st2 = stk | (|(mn & ~({48{1'b1}} << sh[5:0])));
      end
    end
    st2 = st2 | (|mt[22:0]);
    inc = mt[23] & (st2 | mt[24]);
    r25 = {1'b0, mt[47:24]} + 25'(inc);
    if (mz) begin
      rnd_val = {sgn, 31'd0};
    end else if (en <= 11'sd0) begin
      rnd_val = {sgn, 7'd0, r25[23], r25[22:0]};
    end else if (en >= 11'sd255) begin
      rnd_val = {sgn, 8'hff, 23'd0};
    end else if (r25[24]) begin
      rnd_val = (en == 11'sd254) ? {sgn, 8'hff, 23'd0} : {sgn, 8'(en + 11'sd1), 23'd0};
    end else begin
      rnd_val = {sgn, en[7:0], r25[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (start) begin
            op_r  <= op;
            a_r   <= a;
            b_r   <= b;
            state <= F_PREP;
          end
        end
        F_PREP: begin
          spec     <= p_spec;
          spec_val <= p_val;
          sgn      <= p_sgn;
          e        <= p_e;
          m        <= p_m;
          stk      <= 1'b0;
          r        <= p_r;
          d        <= p_d;
          cnt      <= '0;
          state    <= (op_r == rwp_pkg::FOP_DIV && !p_spec) ? F_DIV : F_NORM;
        end
        F_DIV: begin
          m   <= {m[46:0], div_ge};
          r   <= {div_rn[24:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_STEPS - 1)) begin
            stk   <= div_rn != 26'd0;
            state <= F_NORM;
          end
        end
        F_NORM: begin
          mn    <= m << lzc48(m);
          en    <= e + 11'sd1 - 11'(lzc48(m));
          mz    <= (m == 48'd0) && !stk;
          state <= F_RND;
        end
        F_RND: begin
          res   <= spec ? spec_val : rnd_val;
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/rwp_datapath.sv
module rwp_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rwp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rwp_pkg::WORD_W-1:0]        cfg_data,
  input  logic [31:0]                       weight_in,
  input  logic                              first_of_pass,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [31:0]                       weight_out,
  input  rwp_pkg::cmd_t                     cmd,
  output rwp_pkg::stat_t                    stat
);

  localparam logic [31:0] SEED_MUL = 32'd1664525;
  localparam logic [31:0] SEED_ADD = 32'd1013904223;
  localparam logic [31:0] F_HALF   = 32'h3f00_0000;
  localparam logic [31:0] F_TWO    = 32'h4000_0000;
  localparam logic [31:0] F_SQ3    = 32'h3fdd_b3d7;
  localparam logic [31:0] F_SQ3X2  = 32'h405d_b3d7;
  localparam logic [31:0] F_QNAN   = 32'h7fc0_0000;
  localparam logic [31:0] EPS_RST  = 32'h3f80_0000;

  logic        use_uniform, update_mode;
  logic [31:0] noise_seed, epsilon, lr, loss;
  logic [31:0] gen, w, t, s, n;
  logic        first;
  logic        fpu_done;
  logic [31:0] fpu_res, opa, opb, gen_next, seed_val;

  function automatic logic [31:0] pick(input rwp_pkg::src_t sel, input logic [31:0] w_v,
      input logic [31:0] t_v, input logic [31:0] s_v, input logic [31:0] n_v,
      input logic [31:0] r_v, input logic [31:0] eps_v, input logic [31:0] lr_v,
      input logic [31:0] loss_v, input logic [31:0] gen_v);
    logic [31:0] v;
    case (sel)
      rwp_pkg::SRC_W:     v = w_v;
      rwp_pkg::SRC_T:     v = t_v;
      rwp_pkg::SRC_S:     v = s_v;
      rwp_pkg::SRC_N:     v = n_v;
      rwp_pkg::SRC_R:     v = r_v;
      rwp_pkg::SRC_EPS:   v = eps_v;
      rwp_pkg::SRC_LR:    v = lr_v;
      rwp_pkg::SRC_LOSS:  v = loss_v;
      rwp_pkg::SRC_GEN:   v = gen_v;
      rwp_pkg::SRC_HALF:  v = F_HALF;
      rwp_pkg::SRC_TWO:   v = F_TWO;
      rwp_pkg::SRC_SQ3:   v = F_SQ3;
      rwp_pkg::SRC_SQ3X2: v = F_SQ3X2;
      default:            v = '0;
    endcase
    return v;
  endfunction

  assign opa = pick(cmd.sel_a, w, t, s, n, fpu_res, epsilon, lr, loss, gen);
  assign opb = pick(cmd.sel_b, w, t, s, n, fpu_res, epsilon, lr, loss, gen);

  always_comb begin
    logic [31:0] x1, x2;
    x1 = gen ^ (gen << 13);
    x2 = x1 ^ (x1 >> 17);
    gen_next = x2 ^ (x2 << 5);
  end

  assign seed_val = noise_seed * SEED_MUL + SEED_ADD;

  rwp_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fpu_start),
    .op    (cmd.fpu_op),
    .a     (opa),
    .b     (opb),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  assign stat.fpu_done    = fpu_done;
  assign stat.first       = first;
  assign stat.use_uniform = use_uniform;
  assign stat.update_mode = update_mode;
  assign stat.den_zero    = t[30:0] == 31'd0;
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_uniform <= 1'b0;
      update_mode <= 1'b0;
      noise_seed  <= '0;
      epsilon     <= EPS_RST;
      lr          <= '0;
      loss        <= '0;
      gen         <= SEED_ADD;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rwp_pkg::CFG_USE_UNIFORM: use_uniform <= cfg_data[0];
          rwp_pkg::CFG_UPDATE_MODE: update_mode <= cfg_data[0];
          rwp_pkg::CFG_NOISE_SEED:  noise_seed  <= cfg_data;
          rwp_pkg::CFG_EPSILON:     epsilon     <= cfg_data;
          rwp_pkg::CFG_LR:          lr          <= cfg_data;
          rwp_pkg::CFG_LOSS:        loss        <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.seed) gen <= seed_val;
      else if (cmd.draw) gen <= gen_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      w     <= weight_in;
      first <= first_of_pass;
    end
    if (fpu_done) begin
      case (cmd.dst)
        rwp_pkg::DST_T: t <= fpu_res;
        rwp_pkg::DST_S: s <= fpu_res;
        rwp_pkg::DST_N: n <= fpu_res;
        default: ;
      endcase
    end
    if (cmd.safe_load) begin
      if ((n[30:23] == 8'hff && n[22:0] != 23'd0) || n[30:0] == 31'd0) t <= F_QNAN;
      else t <= {n[31] ^ t[31], 8'hff, 23'd0};
    end
    if (cmd.load_out) weight_out <= fpu_res;
  end

endmodule

>>> rtl/core/rwp_ctrl.sv
module rwp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rwp_pkg::stat_t  stat,
  output rwp_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_DRAW1, S_CVT1, S_DRAW2, S_CVT2, S_SAMP,
    S_PSC, S_PSC2, S_PMUL, S_PADD,
    S_UNUM, S_UDEN, S_UDIV, S_UC1, S_UC2, S_USUB, S_OUT
  } state_t;

  state_t state, fpu_next;
  logic   issued;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    fpu_next = S_OUT;
    cmd.load_item = in_valid && (state == S_IDLE);
    case (state)
      S_SEED:  cmd.seed = stat.first;
      S_DRAW1: cmd.draw = 1'b1;
      S_DRAW2: cmd.draw = 1'b1;
      S_CVT1: begin
        cmd.fpu_op = rwp_pkg::FOP_CVT; cmd.sel_a = rwp_pkg::SRC_GEN;
        cmd.dst = rwp_pkg::DST_T;
        fpu_next = stat.use_uniform ? S_SAMP : S_DRAW2;
      end
      S_CVT2: begin
        cmd.fpu_op = rwp_pkg::FOP_CVT; cmd.sel_a = rwp_pkg::SRC_GEN;
        fpu_next = S_SAMP;
      end
      S_SAMP: begin
        cmd.fpu_op = rwp_pkg::FOP_SUB; cmd.sel_a = rwp_pkg::SRC_T;
        cmd.sel_b = stat.use_uniform ? rwp_pkg::SRC_HALF : rwp_pkg::SRC_R;
        cmd.dst = rwp_pkg::DST_S;
        fpu_next = stat.update_mode ? S_UNUM : S_PSC;
      end
      S_PSC: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_EPS;
        cmd.sel_b = rwp_pkg::SRC_SQ3; cmd.dst = rwp_pkg::DST_T;
        fpu_next = stat.use_uniform ? S_PSC2 : S_PMUL;
      end
      S_PSC2: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_T;
        cmd.sel_b = rwp_pkg::SRC_TWO; cmd.dst = rwp_pkg::DST_T;
        fpu_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_S;
        cmd.sel_b = rwp_pkg::SRC_T; cmd.dst = rwp_pkg::DST_T;
        fpu_next = S_PADD;
      end
      S_PADD: begin
        cmd.fpu_op = rwp_pkg::FOP_ADD; cmd.sel_a = rwp_pkg::SRC_W;
        cmd.sel_b = rwp_pkg::SRC_T;
        fpu_next = S_OUT;
      end
      S_UNUM: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_LR;
        cmd.sel_b = rwp_pkg::SRC_LOSS; cmd.dst = rwp_pkg::DST_N;
        fpu_next = S_UDEN;
      end
      S_UDEN: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_TWO;
        cmd.sel_b = rwp_pkg::SRC_EPS; cmd.dst = rwp_pkg::DST_T;
        fpu_next = S_UDIV;
      end
      S_UDIV: begin
        cmd.fpu_op = rwp_pkg::FOP_DIV; cmd.sel_a = rwp_pkg::SRC_N;
        cmd.sel_b = rwp_pkg::SRC_T; cmd.dst = rwp_pkg::DST_T;
        cmd.safe_load = !issued && stat.den_zero;
        fpu_next = S_UC1;
      end
      S_UC1: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_T;
        cmd.sel_b = rwp_pkg::SRC_S; cmd.dst = rwp_pkg::DST_T;
        fpu_next = S_UC2;
      end
      S_UC2: begin
        cmd.fpu_op = rwp_pkg::FOP_MUL; cmd.sel_a = rwp_pkg::SRC_T;
        cmd.sel_b = stat.use_uniform ? rwp_pkg::SRC_SQ3X2 : rwp_pkg::SRC_SQ3;
        cmd.dst = rwp_pkg::DST_T;
        fpu_next = S_USUB;
      end
      S_USUB: begin
        cmd.fpu_op = rwp_pkg::FOP_SUB; cmd.sel_a = rwp_pkg::SRC_W;
        cmd.sel_b = rwp_pkg::SRC_T;
        fpu_next = S_OUT;
      end
      S_OUT: cmd.load_out = stat.out_free;
      default: ;
    endcase
    if (state == S_CVT1 || state == S_CVT2 || state == S_SAMP || state == S_PSC ||
        state == S_PSC2 || state == S_PMUL || state == S_PADD || state == S_UNUM ||
        state == S_UDEN || state == S_UC1 || state == S_UC2 || state == S_USUB ||
        (state == S_UDIV && !stat.den_zero)) begin
      cmd.fpu_start = !issued;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_SEED;
        S_SEED:  state <= S_DRAW1;
        S_DRAW1: state <= S_CVT1;
        S_DRAW2: state <= S_CVT2;
        S_OUT:   if (stat.out_free) state <= S_IDLE;
        default: begin
          if (cmd.safe_load) begin
            state <= fpu_next;
          end else if (!issued) begin
            issued <= 1'b1;
          end else if (stat.fpu_done) begin
            issued <= 1'b0;
            state  <= fpu_next;
          end
        end
      endcase
    end
  end

endmodule

>>> bench/random_weight_perturbation_top_tb.sv
module random_weight_perturbation_top_tb;

  localparam bit [31:0] QNAN     = 32'h7fc00000;
  localparam bit [31:0] F_HALF   = 32'h3f000000;
  localparam bit [31:0] F_TWO    = 32'h40000000;
  localparam bit [31:0] F_SQRT3  = 32'h3fddb3d7;
  localparam bit [31:0] SEED_MUL = 32'd1664525;
  localparam bit [31:0] SEED_ADD = 32'd1013904223;
  localparam int        LIMIT    = 3000000;
  localparam int        DRAIN    = 150;
  localparam int        BLOCKS   = 33;
  localparam int        PER_BLK  = 50;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [rwp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rwp_pkg::WORD_W-1:0]    cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] weight_in;
  logic        first_of_pass;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] weight_out;

  int  cycles;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  rx_hold_req;

  random_weight_perturbation_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .weight_in(weight_in), .first_of_pass(first_of_pass),
    .out_valid(out_valid), .out_ready(out_ready), .weight_out(weight_out)
  );

  function automatic bit is_nan(bit [31:0] x);
    return x[30:23] == 8'hff && x[22:0] != 0;
  endfunction

  function automatic bit is_inf(bit [31:0] x);
    return x[30:23] == 8'hff && x[22:0] == 0;
  endfunction

  function automatic void fp_unpack(input bit [31:0] x, output bit [63:0] sig, output int ex);
    if (x[30:23] == 0) begin
      sig = {41'b0, x[22:0]};
      ex  = -149;
    end else begin
      sig = {40'b0, 1'b1, x[22:0]};
      ex  = int'(x[30:23]) - 150;
    end
  endfunction

  // value = mag * 2^ex, plus a fraction below the lsb when stk is set
  function automatic bit [31:0] fp_round(bit s, int ex, bit [63:0] mag, bit stk);
    int p;
    int q;
    int sh;
    bit [63:0] m;
    bit g;
    bit st;
    p = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) p = i;
    q = ex + p - 23;
    if (q < -149) q = -149;
    sh = q - ex;
    if (sh > 63) begin
      m = 0;
      g = 0;
      st = 1;
    end else if (sh > 0) begin
      m  = mag >> sh;
      g  = mag[sh-1];
      st = stk || ((mag & ((64'd1 << (sh - 1)) - 1)) != 0);
    end else begin
      m  = mag << (-sh);
      g  = 0;
      st = stk;
    end
    if (g && (st || m[0])) m = m + 1;
    if (m[24]) begin
      m = m >> 1;
      q = q + 1;
    end
    if (m == 0) return {s, 31'b0};
    if (m[23]) begin
      if (q + 150 >= 255) return {s, 8'hff, 23'b0};
      return {s, 8'(q + 150), m[22:0]};
    end
    return {s, 8'b0, m[22:0]};
  endfunction

  function automatic bit [31:0] fp_add(bit [31:0] a, bit [31:0] b);
    bit [31:0] t;
    bit [63:0] sa;
    bit [63:0] sb;
    bit [63:0] ma;
    bit [63:0] mb;
    bit [63:0] mag;
    int ea;
    int eb;
    int d;
    bit st;
    if (is_nan(a)) return a | 32'h00400000;
    if (is_nan(b)) return b | 32'h00400000;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    if (a[30:0] < b[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    fp_unpack(a, sa, ea);
    fp_unpack(b, sb, eb);
    d  = ea - eb;
    ma = sa << 38;
    if (d > 60) begin
      mb = 0;
      st = sb != 0;
    end else begin
      mb = (sb << 38) >> d;
      st = ((sb << 38) & ((64'd1 << d) - 1)) != 0;
    end
    if (a[31] == b[31]) mag = ma + mb;
    else mag = ma - mb - 64'(st);
    if (mag == 0 && !st) return 32'h0;
    return fp_round(a[31], ea - 38, mag, st);
  endfunction

  function automatic bit [31:0] fp_mul(bit [31:0] a, bit [31:0] b);
    bit s;
    bit [63:0] sa;
    bit [63:0] sb;
    int ea;
    int eb;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | 32'h00400000;
    if (is_nan(b)) return b | 32'h00400000;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'b0};
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'b0};
    fp_unpack(a, sa, ea);
    fp_unpack(b, sb, eb);
    return fp_round(s, ea + eb, sa * sb, 1'b0);
  endfunction

  // zero divisor gives a canonical NaN or a signed infinity
  function automatic bit [31:0] fp_div_guarded(bit [31:0] a, bit [31:0] b);
    bit s;
    bit [63:0] sa;
    bit [63:0] sb;
    int ea;
    int eb;
    s = a[31] ^ b[31];
    if (b[30:0] == 0) begin
      if (is_nan(a) || a[30:0] == 0) return QNAN;
      return {s, 8'hff, 23'b0};
    end
    if (is_nan(a)) return a | 32'h00400000;
    if (is_nan(b)) return b | 32'h00400000;
    if (is_inf(a) && is_inf(b)) return QNAN;
    if (is_inf(a)) return {s, 8'hff, 23'b0};
    if (is_inf(b) || a[30:0] == 0) return {s, 31'b0};
    fp_unpack(a, sa, ea);
    fp_unpack(b, sb, eb);
    while (!sa[23]) begin
      sa = sa << 1;
      ea = ea - 1;
    end
    while (!sb[23]) begin
      sb = sb << 1;
      eb = eb - 1;
    end
    return fp_round(s, ea - eb - 40, (sa << 40) / sb, ((sa << 40) % sb) != 0);
  endfunction

  class weight_scoreboard;
    bit        uniform;
    bit        update;
    bit [31:0] seed;
    bit [31:0] eps;
    bit [31:0] lr;
    bit [31:0] loss;
    bit [31:0] gen;
    bit [31:0] expected_weights[$];
    int        errors;

    function void reset_state();
      uniform = 0;
      update  = 0;
      seed    = 0;
      eps     = 32'h3f800000;
      lr      = 0;
      loss    = 0;
      gen     = SEED_ADD;
    endfunction

    function void write_reg(logic [rwp_pkg::CFG_IDX_W-1:0] idx, bit [31:0] v);
      case (idx)
        rwp_pkg::CFG_USE_UNIFORM: uniform = v[0];
        rwp_pkg::CFG_UPDATE_MODE: update  = v[0];
        rwp_pkg::CFG_NOISE_SEED:  seed    = v;
        rwp_pkg::CFG_EPSILON:     eps     = v;
        rwp_pkg::CFG_LR:          lr      = v;
        rwp_pkg::CFG_LOSS:        loss    = v;
        default: ;
      endcase
    endfunction

    function bit [31:0] next_unit();
      gen = gen ^ (gen << 13);
      gen = gen ^ (gen >> 17);
      gen = gen ^ (gen << 5);
      return fp_round(1'b0, -32, {32'b0, gen}, 1'b0);
    endfunction

    function void note_input(bit [31:0] w, bit first);
      bit [31:0] sample;
      bit [31:0] u1;
      bit [31:0] scale;
      bit [31:0] coef;
      if (first) gen = seed * SEED_MUL + SEED_ADD;
      if (uniform) begin
        sample = fp_add(next_unit(), F_HALF ^ 32'h80000000);
      end else begin
        u1 = next_unit();
        sample = fp_add(u1, next_unit() ^ 32'h80000000);
      end
      if (update) begin
        scale = uniform ? fp_mul(F_SQRT3, F_TWO) : F_SQRT3;
        coef = fp_div_guarded(fp_mul(lr, loss), fp_mul(F_TWO, eps));
        expected_weights.push_back(
          fp_add(w, fp_mul(fp_mul(coef, sample), scale) ^ 32'h80000000));
      end else begin
        scale = fp_mul(eps, F_SQRT3);
        if (uniform) scale = fp_mul(scale, F_TWO);
        expected_weights.push_back(fp_add(w, fp_mul(sample, scale)));
      end
    endfunction

    function void check_result(bit [31:0] got);
      bit [31:0] want;
      if (expected_weights.size() == 0) begin
        $error("weight_out: unexpected transaction, actual %h", got);
        errors++;
        return;
      end
      want = expected_weights.pop_front();
      if (!(want == got || (is_nan(want) && is_nan(got)))) begin
        $error("weight_out: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  weight_scoreboard sb;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("random_weight_perturbation_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(weight_out);
  end

  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        rx_hold_req = 0;
      end
      out_ready = $urandom_range(99) >= rx_idle_pct;
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [rwp_pkg::CFG_IDX_W-1:0] idx, bit [31:0] v);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data  = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_write = 0;
  endtask

  task automatic set_config(bit uni, bit upd, bit [31:0] seed, bit [31:0] eps,
                            bit [31:0] lr, bit [31:0] loss);
    write_reg(rwp_pkg::CFG_USE_UNIFORM, 32'(uni));
    write_reg(rwp_pkg::CFG_UPDATE_MODE, 32'(upd));
    write_reg(rwp_pkg::CFG_NOISE_SEED, seed);
    write_reg(rwp_pkg::CFG_EPSILON, eps);
    write_reg(rwp_pkg::CFG_LR, lr);
    write_reg(rwp_pkg::CFG_LOSS, loss);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (sb.expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_weight(bit [31:0] w, bit first);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid      = 1;
    weight_in     = w;
    first_of_pass = first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w, first);
  endtask

  function automatic bit [31:0] pick_float();
    case ($urandom_range(9))
      0: return $urandom();
      1: return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
      2: return {1'($urandom_range(1)), 8'hff, 23'($urandom_range(1) ? $urandom() : 0)};
      3: return {1'($urandom_range(1)), 31'h0};
      4: return {1'($urandom_range(1)), 8'hfe, 23'($urandom())};
      default: return {1'($urandom_range(1)), 8'($urandom_range(140, 110)), 23'($urandom())};
    endcase
  endfunction

  function automatic bit [31:0] pick_weight();
    if ($urandom_range(3) == 0) return pick_float();
    return {1'($urandom_range(1)), 8'($urandom_range(130, 118)), 23'($urandom())};
  endfunction

  // seed whose pass start leaves the generator at zero
  function automatic bit [31:0] zero_state_seed();
    bit [31:0] inv;
    inv = SEED_MUL;
    repeat (5) inv = inv * (32'd2 - SEED_MUL * inv);
    return (32'd0 - SEED_ADD) * inv;
  endfunction

  initial begin
    bit [31:0] eps;
    sb = new();
    sb.reset_state();
    sb.errors   = 0;
    cycles      = 0;
    rst         = 1;
    cfg_write   = 0;
    cfg_index   = rwp_pkg::CFG_USE_UNIFORM;
    cfg_data    = 0;
    in_valid    = 0;
    weight_in   = 0;
    first_of_pass = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_weight(32'h3f800000, 0);
    send_weight(32'h00000000, 1);
    send_weight(32'h80000000, 0);
    send_weight(32'h7f800000, 0);
    send_weight(32'hff800000, 0);
    send_weight(32'h7fc00000, 0);
    send_weight(32'h7f7fffff, 1);
    send_weight(32'h00000001, 0);
    send_weight(32'hffffffff, 0);
    wait_drained();
    set_config(1, 0, 32'hffffffff, 32'h7f7fffff, 0, 0);
    send_weight(32'h3f800000, 1);
    send_weight(32'hbf800000, 0);
    send_weight(32'h00000000, 0);
    wait_drained();
    set_config(0, 1, 32'h12345678, 32'h00000000, 32'h3c23d70a, 32'h40400000);
    send_weight(32'h3f000000, 1);
    send_weight(32'hc0000000, 0);
    wait_drained();
    set_config(1, 1, 32'h0, 32'h80000000, 32'h00000000, 32'h40400000);
    send_weight(32'h3f000000, 1);
    send_weight(32'h3f000000, 0);
    wait_drained();
    set_config(1, 1, zero_state_seed(), 32'h3c23d70a, 32'hbf800000, 32'h3e800000);
    send_weight(32'h41200000, 1);
    send_weight(32'h41200000, 0);
    wait_drained();
    set_config(0, 0, zero_state_seed(), 32'h00400000, 0, 0);
    send_weight(32'h00000003, 1);
    send_weight(32'h3f800000, 0);
    wait_drained();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk < 11) begin
        tx_idle_pct = 11;
        rx_idle_pct = 66;
      end else if (blk < 22) begin
        tx_idle_pct = 66;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      eps = ($urandom_range(3) == 0) ? pick_float()
          : {1'b0, 8'($urandom_range(128, 110)), 23'($urandom())};
      set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(4) == 0 ? {32{1'($urandom_range(1))}} : $urandom(),
                 eps, pick_float(), pick_float());
      if (blk == 3 || blk == 14 || blk == 25) rx_hold_req = 1;
      for (int i = 0; i < PER_BLK; i++)
        send_weight(pick_weight(), i == 0 || $urandom_range(11) == 0);
      @(negedge clk);
      in_valid = 0;
      wait_drained();
    end

    if (sb.errors == 0 && sb.expected_weights.size() == 0)
      $display("random_weight_perturbation_top verification clean");
    else
      $display("random_weight_perturbation_top verification failed");
    $finish;
  end
endmodule
